// File: hdl/block_average_iir_voltage_filter_assert.svh
// Assertion macros for the filter's back end, the only module that includes this file.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef BLOCK_AVERAGE_IIR_VOLTAGE_FILTER_ASSERT_SVH
`define BLOCK_AVERAGE_IIR_VOLTAGE_FILTER_ASSERT_SVH

`ifndef SYNTHESIS
`define BAVF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in the same cycle");
`define BAVF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in the next cycle");
`else
`define BAVF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BAVF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/bavf_pkg.sv
package bavf_pkg;

  localparam int BLOCK_SAMPLES = 32;
  localparam int SAMPLE_BITS   = 12;

  localparam int CNT_W   = $clog2(BLOCK_SAMPLES);
  localparam int SUM_W   = SAMPLE_BITS + $clog2(BLOCK_SAMPLES);

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 1'd1;
  localparam logic [CFG_W-1:0] SCALE_RESET = 16'd28167;
  localparam logic [CFG_W-1:0] ALPHA_RESET = 16'd3277;

  localparam int VOLT_W  = 16;
  localparam int FILT_W  = 24;
  localparam int Q_SHIFT = 16;
  localparam int PROD1_W = (SUM_W + CFG_W > 33) ? (SUM_W + CFG_W) : 33;
  localparam int PROD2_W = FILT_W + CFG_W;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic not_empty;
    logic not_full;
  } q_stat_t;

endpackage

// File: hdl/block_average_iir_voltage_filter.sv
// Block-average voltage filter: every 32 accepted 12-bit samples (one beat each, one beat per
// cycle at most) are summed, scaled by scale_factor (Q16) to Q8.8 volts with saturation, and
// passed through a first-order low-pass with weight smoothing_alpha (Q0.16); the first block
// after reset loads the filter directly and is flagged by out_first_block. One result beat
// leaves per block, after the registered scale product for the first block and after both
// the scale product and the registered filter product for the rest. Completed block
// sums wait in a two-entry queue, so in_stall rises only when the back end is held up by
// out_stall long enough for that queue to fill.
module block_average_iir_voltage_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bavf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bavf_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bavf_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bavf_pkg::VOLT_W-1:0]   out_voltage,
  output logic                          out_first_block
);
  import bavf_pkg::*;

  q_stat_t          q_stat;
  logic             q_push;
  logic             q_pop;
  logic [SUM_W-1:0] q_wdata;
  logic [SUM_W-1:0] q_rdata;

  bavf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  bavf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  bavf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .q_rdata         (q_rdata),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_voltage     (out_voltage),
    .out_first_block (out_first_block)
  );

endmodule

// File: hdl/bavf_front.sv
module bavf_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bavf_pkg::SAMPLE_BITS-1:0] in_sample,
  input  bavf_pkg::q_stat_t           q_stat,
  output logic                        q_push,
  output logic [bavf_pkg::SUM_W-1:0]  q_wdata
);
  import bavf_pkg::*;

  logic [SUM_W-1:0] sum_r, sum_nxt, sum_add;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic             last;

  assign in_stall = !q_stat.not_full;
  assign accept   = in_valid && !in_stall;
  assign sum_add  = sum_r + SUM_W'(in_sample);
  assign last     = (cnt_r == CNT_W'(BLOCK_SAMPLES - 1));
  assign q_push   = accept && last;
  assign q_wdata  = sum_add;

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (last) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hdl/bavf_queue.sv
module bavf_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [bavf_pkg::SUM_W-1:0] wdata,
  input  logic                       pop,
  output logic [bavf_pkg::SUM_W-1:0] rdata,
  output bavf_pkg::q_stat_t          stat
);
  import bavf_pkg::*;

  logic [SUM_W-1:0]  mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign stat.not_empty = (cnt_r != '0);
  assign stat.not_full  = (cnt_r != QCNT_W'(QDEPTH));
  assign do_push = push && stat.not_full;
  assign do_pop  = pop && stat.not_empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

// File: hdl/bavf_back.sv
module bavf_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bavf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bavf_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [bavf_pkg::SUM_W-1:0]    q_rdata,
  input  bavf_pkg::q_stat_t             q_stat,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bavf_pkg::VOLT_W-1:0]   out_voltage,
  output logic                          out_first_block
);
  import bavf_pkg::*;

  `include "block_average_iir_voltage_filter_assert.svh"

  typedef enum logic [1:0] {S_IDLE, S_SAT, S_UPD} state_t;

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   scale_r, scale_nxt;
  logic [CFG_W-1:0]   alpha_r, alpha_nxt;
  logic               primed_r, primed_nxt;
  logic [FILT_W-1:0]  filt_r, filt_nxt;
  logic [PROD1_W-1:0] prod1_r, prod1_nxt;
  logic [PROD2_W-1:0] prod2_r, prod2_nxt;
  logic               neg_r, neg_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VOLT_W-1:0]  voltage_r, voltage_nxt;
  logic               first_r, first_nxt;

  logic [PROD1_W-1:0] hi;
  logic [VOLT_W-1:0]  raw;
  logic [FILT_W-1:0]  target;
  logic [FILT_W-1:0]  diff;
  logic [FILT_W-1:0]  step;
  logic [FILT_W-1:0]  filt_new;

  assign q_pop           = (state_r == S_IDLE) && q_stat.not_empty && !out_valid_r;
  assign out_valid       = out_valid_r;
  assign out_voltage     = voltage_r;
  assign out_first_block = first_r;

  // Scaled block sum, saturated to the 16-bit Q8.8 range.
  assign hi     = prod1_r >> Q_SHIFT;
  assign raw    = (hi > PROD1_W'(16'hFFFF)) ? 16'hFFFF : hi[VOLT_W-1:0];
  assign target = {raw, 8'h00};
  assign diff   = (target < filt_r) ? (filt_r - target) : (target - filt_r);

  // A falling step is rounded up in magnitude so the filter floors toward minus infinity.
  always_comb begin
    if (neg_r) begin
      step = FILT_W'(((PROD2_W + 1)'(prod2_r) + (PROD2_W + 1)'(16'hFFFF)) >> Q_SHIFT);
      filt_new = filt_r - step;
    end else begin
      step = FILT_W'(prod2_r >> Q_SHIFT);
      filt_new = filt_r + step;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    scale_nxt     = scale_r;
    alpha_nxt     = alpha_r;
    primed_nxt    = primed_r;
    filt_nxt      = filt_r;
    prod1_nxt     = prod1_r;
    prod2_nxt     = prod2_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    voltage_nxt   = voltage_r;
    first_nxt     = first_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_SCALE: scale_nxt = cfg_wdata;
        REG_ALPHA: alpha_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          prod1_nxt = PROD1_W'(q_rdata) * PROD1_W'(scale_r);
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        if (!primed_r) begin
          filt_nxt      = target;
          primed_nxt    = 1'b1;
          voltage_nxt   = raw;
          first_nxt     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          neg_nxt   = (target < filt_r);
          prod2_nxt = PROD2_W'(diff) * PROD2_W'(alpha_r);
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        filt_nxt      = filt_new;
        voltage_nxt   = filt_new[FILT_W-1:FILT_W-VOLT_W];
        first_nxt     = 1'b0;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scale_r     <= SCALE_RESET;
      alpha_r     <= ALPHA_RESET;
      primed_r    <= 1'b0;
      filt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scale_r     <= scale_nxt;
      alpha_r     <= alpha_nxt;
      primed_r    <= primed_nxt;
      filt_r      <= filt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prod1_r   <= prod1_nxt;
    prod2_r   <= prod2_nxt;
    neg_r     <= neg_nxt;
    voltage_r <= voltage_nxt;
    first_r   <= first_nxt;
  end

  `BAVF_ASSERT_IMP(a_busy_no_result, clk, rst_n, state_r != S_IDLE, !out_valid_r)
  `BAVF_ASSERT_NXT(a_primed_sticky, clk, rst_n, primed_r, primed_r)
  `BAVF_ASSERT_IMP(a_update_primed, clk, rst_n, state_r == S_UPD, primed_r)
  `BAVF_ASSERT_NXT(a_first_load, clk, rst_n, state_r == S_SAT && !primed_r, out_valid_r && first_r)

endmodule

// File: test/block_average_iir_voltage_filter_tb.sv
module block_average_iir_voltage_filter_tb;
  import bavf_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1100;
  localparam int SETTLE       = 8;
  localparam int MAX_IDLE     = 16;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

  typedef struct packed {
    logic [VOLT_W-1:0] voltage;
    logic              first_block;
  } volt_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   in_valid;
  logic                   in_stall;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   out_valid;
  logic                   out_stall;
  logic [VOLT_W-1:0]      out_voltage;
  logic                   out_first_block;

  // Predictor state: register copies, running block sum and the Q8.16 filter.
  logic [CFG_W-1:0]  scale_reg;
  logic [CFG_W-1:0]  alpha_reg;
  logic [SUM_W-1:0]  acc_sum;
  int                acc_count;
  logic [FILT_W-1:0] filt_q816;
  logic              filt_loaded;

  volt_result_t pending_volts[$];
  int           error_count = 0;
  int           cycle_count = 0;
  bit           tx_idle_on;
  bit           rx_idle_on;

  block_average_iir_voltage_filter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_voltage     (out_voltage),
    .out_first_block (out_first_block)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[block_average_iir_voltage_filter] ERROR");
      $finish;
    end
  end

  // Scales a closed block to Q8.8 volts, saturating at full range.
  function automatic logic [VOLT_W-1:0] scale_to_volts(logic [SUM_W-1:0] sum,
                                                       logic [CFG_W-1:0] scale);
    logic [63:0] prod;
    prod = (64'(sum) * 64'(scale)) >> Q_SHIFT;
    return (prod > 64'hFFFF) ? {VOLT_W{1'b1}} : prod[VOLT_W-1:0];
  endfunction

  // One low-pass step; a downward step rounds toward minus infinity.
  function automatic logic [FILT_W-1:0] lowpass_step(logic [FILT_W-1:0] filt,
                                                     logic [FILT_W-1:0] target,
                                                     logic [CFG_W-1:0] alpha);
    logic [63:0] diff;
    logic [63:0] delta;
    if (target >= filt) begin
      diff  = 64'(target - filt);
      delta = (64'(alpha) * diff) >> Q_SHIFT;
      return filt + delta[FILT_W-1:0];
    end else begin
      diff  = 64'(filt - target);
      delta = (64'(alpha) * diff + 64'd65535) >> Q_SHIFT;
      return filt - delta[FILT_W-1:0];
    end
  endfunction

  task automatic accumulate_sample(input logic [SAMPLE_BITS-1:0] s);
    logic [VOLT_W-1:0] raw;
    volt_result_t      res;
    acc_sum   = acc_sum + SUM_W'(s);
    acc_count = acc_count + 1;
    if (acc_count == BLOCK_SAMPLES) begin
      raw = scale_to_volts(acc_sum, scale_reg);
      acc_sum   = '0;
      acc_count = 0;
      if (!filt_loaded) begin
        filt_q816       = {raw, 8'h00};
        filt_loaded     = 1'b1;
        res.first_block = 1'b1;
      end else begin
        filt_q816       = lowpass_step(filt_q816, {raw, 8'h00}, alpha_reg);
        res.first_block = 1'b0;
      end
      res.voltage = filt_q816[FILT_W-1:8];
      pending_volts.push_back(res);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_SCALE: scale_reg = value;
      REG_ALPHA: alpha_reg = value;
      default: ;
    endcase
  endtask

  // Valid stays high from one beat to the next unless a gap is drawn.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    accumulate_sample(s);
  endtask

  task automatic send_constant_block(input logic [SAMPLE_BITS-1:0] s);
    repeat (BLOCK_SAMPLES) send_sample(s);
  endtask

  // Drops valid, waits out every expected result and lets the pipeline settle.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_volts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] draw_reg_value(logic [CFG_W-1:0] reset_value);
    case ($urandom_range(0, 4))
      0: return '0;
      1: return {CFG_W{1'b1}};
      2: return reset_value;
      default: return CFG_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly a noisy steady level, as from a real voltage channel, plus outliers.
  function automatic logic [SAMPLE_BITS-1:0] draw_sample(int level, int noise);
    int pick;
    int v;
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      v = level + $urandom_range(0, 2 * noise) - noise;
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      return SAMPLE_BITS'(v);
    end else if (pick < 17) begin
      return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
    end else begin
      return pick[0] ? SAMPLE_MAX : '0;
    end
  endfunction

  // Compares each result beat with the oldest expectation.
  always @(posedge clk) begin
    volt_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_volts.size() == 0) begin
        $display("%0t: unexpected result beat, voltage %0d first_block %0b",
                 $time, out_voltage, out_first_block);
        error_count++;
      end else begin
        want = pending_volts.pop_front();
        if (out_voltage !== want.voltage) begin
          $display("%0t: voltage expected %0d got %0d", $time, want.voltage, out_voltage);
          error_count++;
        end
        if (out_first_block !== want.first_block) begin
          $display("%0t: first_block expected %0b got %0b",
                   $time, want.first_block, out_first_block);
          error_count++;
        end
      end
    end
  end

  // Result side holds stall for a drawn number of cycles before each beat.
  initial begin
    int waits;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      waits = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      repeat (waits) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic test_default_settings();
    repeat (BLOCK_SAMPLES) send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
    drain_results();
  endtask

  // Saturating full-scale block, then a full drop to zero, a frozen filter and a zero scale.
  task automatic test_extremes();
    write_reg(REG_SCALE, {CFG_W{1'b1}});
    write_reg(REG_ALPHA, {CFG_W{1'b1}});
    send_constant_block(SAMPLE_MAX);
    send_constant_block('0);
    drain_results();
    write_reg(REG_ALPHA, '0);
    send_constant_block(SAMPLE_MAX);
    drain_results();
    write_reg(REG_SCALE, '0);
    write_reg(REG_ALPHA, 16'h8000);
    send_constant_block(12'hA5A);
    drain_results();
  endtask

  // New register values written inside a block apply when that block closes.
  task automatic test_midblock_write();
    write_reg(REG_SCALE, SCALE_RESET);
    repeat (13) send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
    drain_results();
    write_reg(REG_SCALE, CFG_W'($urandom_range(20000, 65535)));
    write_reg(REG_ALPHA, CFG_W'($urandom_range(1, 65535)));
    repeat (BLOCK_SAMPLES - 13) send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
    drain_results();
  endtask

  task automatic test_random_phases();
    int sent;
    int phase_len;
    int level;
    int noise;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1)) write_reg(REG_SCALE, draw_reg_value(SCALE_RESET));
      if ($urandom_range(0, 1)) write_reg(REG_ALPHA, draw_reg_value(ALPHA_RESET));
      tx_idle_on = ($urandom_range(0, 2) != 0);
      rx_idle_on = ($urandom_range(0, 2) != 0);
      phase_len  = $urandom_range(1, 5 * BLOCK_SAMPLES);
      level      = $urandom_range(0, SAMPLE_MAX);
      noise      = $urandom_range(0, 300);
      repeat (phase_len) send_sample(draw_sample(level, noise));
      sent += phase_len;
      drain_results();
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_SCALE;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_sample   = '0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    scale_reg   = SCALE_RESET;
    alpha_reg   = ALPHA_RESET;
    acc_sum     = '0;
    acc_count   = 0;
    filt_q816   = '0;
    filt_loaded = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_settings();
    test_extremes();
    test_midblock_write();
    test_random_phases();

    if (error_count == 0) begin
      $display("[block_average_iir_voltage_filter] OK");
    end else begin
      $display("[block_average_iir_voltage_filter] ERROR");
    end
    $finish;
  end

endmodule
